// ===== rtl/core/shared_exclusive_lock_queue_assert.svh =====
// Assertion macros for the shared/exclusive lock queue.
// Included at the end of the top level; expects clock and reset in scope.
`ifndef SHARED_EXCLUSIVE_LOCK_QUEUE_ASSERT_SVH
`define SHARED_EXCLUSIVE_LOCK_QUEUE_ASSERT_SVH

// same-cycle implication
`define SELQ_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("selq assertion failed");

// next-cycle implication
`define SELQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("selq assertion failed");

`endif

// ===== rtl/core/selq_pkg.sv =====
// Package for the shared/exclusive lock queue: sizes, codes, transaction
// structs, sequencer states and grant-decision helpers. No dependencies.
package selq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int HOLDER_DEPTH = 16;
   localparam int TAG_W        = 6;
   localparam int OWNER_W      = 8;
   localparam int KIND_W       = 2;
   localparam int EV_W         = 3;
   localparam int CNT_W        = 5;

   localparam int QIDX_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int HIDX_W = $clog2(HOLDER_DEPTH);
   localparam int HCNT_W = $clog2(HOLDER_DEPTH + 1);

   localparam logic [KIND_W-1:0] KIND_LOCK    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

   localparam logic [EV_W-1:0] EV_QUEUED       = 3'd0;
   localparam logic [EV_W-1:0] EV_BUSY         = 3'd1;
   localparam logic [EV_W-1:0] EV_FULL         = 3'd2;
   localparam logic [EV_W-1:0] EV_RELEASED     = 3'd3;
   localparam logic [EV_W-1:0] EV_REL_UNKNOWN  = 3'd4;
   localparam logic [EV_W-1:0] EV_CANCELLED    = 3'd5;
   localparam logic [EV_W-1:0] EV_CANCEL_STALE = 3'd6;
   localparam logic [EV_W-1:0] EV_GRANTED      = 3'd7;

   typedef enum logic [1:0] {
      LK_UNLOCKED = 2'd0,
      LK_SHARED   = 2'd1,
      LK_EXCL     = 2'd2
   } lock_state_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REQ,
      ST_HSRCH,
      ST_HREL,
      ST_WSRCH,
      ST_WCAN,
      ST_MISS,
      ST_GRANT
   } state_type;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [TAG_W-1:0]   tag;
      logic [OWNER_W-1:0] owner;
      logic               mode;
      logic               try_only;
   } req_type;

   typedef struct packed {
      logic [EV_W-1:0]    event_res;
      logic [TAG_W-1:0]   tag_res;
      logic [OWNER_W-1:0] owner_res;
      logic               granted_mode;
      logic [CNT_W-1:0]   held_count;
      logic [CNT_W-1:0]   pending_count;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [TAG_W-1:0]   tag;
      logic [OWNER_W-1:0] owner;
      logic               mode;
   } wait_entry_type;

   typedef struct packed {
      logic              append;
      logic              remove;
      logic [QIDX_W-1:0] rm_idx;
      logic [QIDX_W-1:0] rd_idx;
   } wq_ctl_type;

   function automatic logic can_acquire(input logic [HCNT_W-1:0] hc,
                                        input lock_state_type lk,
                                        input logic md);
      return (hc == '0) || (lk == LK_UNLOCKED) || (!md && (lk == LK_SHARED));
   endfunction

   function automatic logic grant_next(input logic waiting,
                                       input logic [HCNT_W-1:0] hc,
                                       input lock_state_type lk,
                                       input logic head_md);
      return waiting && (hc < HCNT_W'(HOLDER_DEPTH)) && can_acquire(hc, lk, head_md);
   endfunction

endpackage

// ===== rtl/core/selq_waitq.sv =====
// Wait queue of the lock: FIFO of pending requests with append at the tail,
// removal at any index by compaction, and one indexed read. Uses selq_pkg.
module selq_waitq (
   input  logic                     clock,
   input  logic                     reset,
   input  selq_pkg::wq_ctl_type     ctl,
   input  selq_pkg::wait_entry_type wr_entry,
   output selq_pkg::wait_entry_type head,
   output selq_pkg::wait_entry_type second,
   output selq_pkg::wait_entry_type rd_entry,
   output logic [selq_pkg::QCNT_W-1:0] count
);
   import selq_pkg::*;

   wait_entry_type    entry_ff [QUEUE_DEPTH];
   logic [QCNT_W-1:0] count_ff;
   logic [QCNT_W-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (ctl.append) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (ctl.remove) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.append) begin
         entry_ff[count_ff[QIDX_W-1:0]] <= wr_entry;
      end
      if (ctl.remove) begin
         for (int k = 0; k < QUEUE_DEPTH - 1; k++) begin
            if (QIDX_W'(k) >= ctl.rm_idx) begin
               entry_ff[k] <= entry_ff[k+1];
            end
         end
      end
   end

   assign head     = entry_ff[0];
   assign second   = entry_ff[1];
   assign rd_entry = entry_ff[ctl.rd_idx];
   assign count    = count_ff;

endmodule

// ===== rtl/core/shared_exclusive_lock_queue.sv =====
// Flow: an accepted lock request is registered and gives its first result once the
// output register is free; a release or cancel walks the holder or wait store one
// entry a cycle and then gives its first result. Grants follow one a cycle while the
// output is not stalled. The next item is taken once the last result sits in the
// output register.
// Reset: synchronous; clears counts, lock state, sequencer and output valid, not the stores.
module shared_exclusive_lock_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  selq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output selq_pkg::rsp_type rsp_data
);
   import selq_pkg::*;

   state_type         state_ff, state_in;
   req_type           item_ff;
   logic [TAG_W-1:0]  holder_ff [HOLDER_DEPTH];
   logic [HCNT_W-1:0] hcount_ff;
   logic [HIDX_W-1:0] hidx_ff, hidx_in;
   logic [QIDX_W-1:0] qidx_ff, qidx_in;
   lock_state_type    lock_ff, lock_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   wq_ctl_type        wq_ctl;
   wait_entry_type    wq_wr, q_head, q_second, q_rd;
   logic [QCNT_W-1:0] q_count;

   logic              req_take;
   logic              out_free;
   logic              emit;
   rsp_type           rsp_new;
   logic              hold_push, hold_pop;

   logic              req_busy, req_full, req_more, req_head_mode;
   logic              rel_more, grant_more;
   lock_state_type    lock_after_rel;
   logic              h_in_range, h_hit, h_end;
   logic              q_in_range, q_hit, q_end;

   selq_waitq u_waitq (
      .clock    (clock),
      .reset    (reset),
      .ctl      (wq_ctl),
      .wr_entry (wq_wr),
      .head     (q_head),
      .second   (q_second),
      .rd_entry (q_rd),
      .count    (q_count)
   );

   assign req_take = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign req_busy      = item_ff.try_only && !can_acquire(hcount_ff, lock_ff, item_ff.mode);
   assign req_full      = q_count == QCNT_W'(QUEUE_DEPTH);
   assign req_head_mode = (q_count == '0) ? item_ff.mode : q_head.mode;
   assign req_more      = grant_next(1'b1, hcount_ff, lock_ff, req_head_mode);

   assign lock_after_rel = (hcount_ff == HCNT_W'(1)) ? LK_UNLOCKED : lock_ff;
   assign rel_more = grant_next(q_count != '0, hcount_ff - HCNT_W'(1), lock_after_rel,
                                q_head.mode);

   // another grant follows only inside a run of shared heads
   assign grant_more = (q_count > QCNT_W'(1)) && (hcount_ff < HCNT_W'(HOLDER_DEPTH - 1))
                       && !q_head.mode && !q_second.mode;

   assign h_in_range = HCNT_W'(hidx_ff) < hcount_ff;
   assign h_hit      = h_in_range && (holder_ff[hidx_ff] == item_ff.tag);
   assign h_end      = hidx_ff == HIDX_W'(HOLDER_DEPTH - 1);
   assign q_in_range = QCNT_W'(qidx_ff) < q_count;
   assign q_hit      = q_in_range && (q_rd.tag == item_ff.tag);
   assign q_end      = qidx_ff == QIDX_W'(QUEUE_DEPTH - 1);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_data.kind)
                  KIND_LOCK:    state_in = ST_REQ;
                  KIND_RELEASE: state_in = ST_HSRCH;
                  KIND_CANCEL:  state_in = ST_WSRCH;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_REQ: begin
            if (out_free) begin
               state_in = (req_busy || req_full || !req_more) ? ST_IDLE : ST_GRANT;
            end
         end
         ST_HSRCH: begin
            if (h_hit) begin
               state_in = ST_HREL;
            end else if (!h_in_range || h_end) begin
               state_in = ST_MISS;
            end
         end
         ST_HREL: begin
            if (out_free) begin
               state_in = rel_more ? ST_GRANT : ST_IDLE;
            end
         end
         ST_WSRCH: begin
            if (q_hit) begin
               state_in = ST_WCAN;
            end else if (!q_in_range || q_end) begin
               state_in = ST_MISS;
            end
         end
         ST_WCAN, ST_MISS: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_GRANT: begin
            if (out_free && !grant_more) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall             = state_ff != ST_IDLE;
      emit                  = 1'b0;
      rsp_new               = '0;
      rsp_new.tag_res       = item_ff.tag;
      rsp_new.held_count    = CNT_W'(hcount_ff);
      rsp_new.pending_count = CNT_W'(q_count);
      wq_ctl                = '0;
      wq_ctl.rd_idx         = qidx_ff;
      wq_wr.tag             = item_ff.tag;
      wq_wr.owner           = item_ff.owner;
      wq_wr.mode            = item_ff.mode;
      hold_push             = 1'b0;
      hold_pop              = 1'b0;
      lock_in               = lock_ff;
      hidx_in               = hidx_ff;
      qidx_in               = qidx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            hidx_in = '0;
            qidx_in = '0;
         end
         ST_REQ: begin
            rsp_new.owner_res    = item_ff.owner;
            rsp_new.granted_mode = item_ff.mode;
            rsp_new.last         = 1'b1;
            if (out_free) begin
               emit = 1'b1;
               if (req_busy) begin
                  rsp_new.event_res = EV_BUSY;
               end else if (req_full) begin
                  rsp_new.event_res = EV_FULL;
               end else begin
                  rsp_new.event_res     = EV_QUEUED;
                  rsp_new.pending_count = CNT_W'(q_count + QCNT_W'(1));
                  rsp_new.last          = !req_more;
                  wq_ctl.append         = 1'b1;
               end
            end
         end
         ST_HSRCH: begin
            if (!h_hit) begin
               hidx_in = hidx_ff + HIDX_W'(1);
            end
         end
         ST_HREL: begin
            rsp_new.event_res    = EV_RELEASED;
            rsp_new.granted_mode = lock_ff == LK_EXCL;
            rsp_new.held_count   = CNT_W'(hcount_ff - HCNT_W'(1));
            rsp_new.last         = !rel_more;
            if (out_free) begin
               emit     = 1'b1;
               hold_pop = 1'b1;
               lock_in  = lock_after_rel;
            end
         end
         ST_WSRCH: begin
            if (!q_hit) begin
               qidx_in = qidx_ff + QIDX_W'(1);
            end
         end
         ST_WCAN: begin
            rsp_new.event_res     = EV_CANCELLED;
            rsp_new.owner_res     = q_rd.owner;
            rsp_new.granted_mode  = q_rd.mode;
            rsp_new.pending_count = CNT_W'(q_count - QCNT_W'(1));
            rsp_new.last          = 1'b1;
            if (out_free) begin
               emit          = 1'b1;
               wq_ctl.remove = 1'b1;
               wq_ctl.rm_idx = qidx_ff;
            end
         end
         ST_MISS: begin
            rsp_new.event_res = (item_ff.kind == KIND_RELEASE) ? EV_REL_UNKNOWN
                                                               : EV_CANCEL_STALE;
            rsp_new.last      = 1'b1;
            emit              = out_free;
         end
         ST_GRANT: begin
            rsp_new.event_res     = EV_GRANTED;
            rsp_new.tag_res       = q_head.tag;
            rsp_new.owner_res     = q_head.owner;
            rsp_new.granted_mode  = q_head.mode;
            rsp_new.held_count    = CNT_W'(hcount_ff + HCNT_W'(1));
            rsp_new.pending_count = CNT_W'(q_count - QCNT_W'(1));
            rsp_new.last          = !grant_more;
            if (out_free) begin
               emit          = 1'b1;
               hold_push     = 1'b1;
               wq_ctl.remove = 1'b1;
               wq_ctl.rm_idx = '0;
               lock_in       = q_head.mode ? LK_EXCL : LK_SHARED;
            end
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         hcount_ff    <= '0;
         lock_ff      <= LK_UNLOCKED;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lock_ff  <= lock_in;
         if (hold_push) begin
            hcount_ff <= hcount_ff + HCNT_W'(1);
         end else if (hold_pop) begin
            hcount_ff <= hcount_ff - HCNT_W'(1);
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      hidx_ff <= hidx_in;
      qidx_ff <= qidx_in;
      if (req_take) begin
         item_ff <= req_data;
      end
      if (emit) begin
         rsp_data_ff <= rsp_new;
      end
      if (hold_push) begin
         holder_ff[hcount_ff[HIDX_W-1:0]] <= q_head.tag;
      end
      if (hold_pop) begin
         for (int k = 0; k < HOLDER_DEPTH - 1; k++) begin
            if (HIDX_W'(k) >= hidx_ff) begin
               holder_ff[k] <= holder_ff[k+1];
            end
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`include "shared_exclusive_lock_queue_assert.svh"

   `SELQ_ASSERT_IMPL(a_hcount_bound, 1'b1, hcount_ff <= HCNT_W'(HOLDER_DEPTH))
   `SELQ_ASSERT_IMPL(a_unlocked_iff_empty, 1'b1, (hcount_ff == '0) == (lock_ff == LK_UNLOCKED))
   `SELQ_ASSERT_NEXT(a_busy_after_take, req_take && (req_data.kind != KIND_UNUSED), req_stall)

endmodule
